// ===== rtl/sis_pkg.sv =====
// Shared types, constants and the multiply program of the Sampson inlier scorer.
package sis_pkg;

  // Set size and field widths
  localparam int MaxPoints = 65536;
  localparam int CountCap  = (MaxPoints < 131071) ? MaxPoints : 131071;
  localparam int IdxW      = 16;
  localparam int CntW      = 17;
  localparam int DistW     = 24;
  localparam int SumW      = 40;
  localparam int PtW       = 20;
  localparam int CoefW     = 21;
  localparam int RowW      = 63;
  localparam int FracW     = 6;
  localparam int ThrW      = 16;
  localparam int CfgIdxW   = 3;
  localparam int CfgW      = 63;

  // Sequencer lengths
  localparam int NumSteps   = 46;
  localparam int StepW      = 6;
  localparam int DivIters   = 48;
  localparam int SqrtIters  = 24;
  localparam int MeanIters  = 40;
  localparam int MaxFrac    = 40;
  localparam int TinyOffset = 44;

  localparam logic [DistW-1:0] Ones24 = '1;
  localparam logic [SumW-1:0]  Ones40 = '1;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_ROW_ZERO  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROW_ONE   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROW_TWO   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_FRAC_BITS = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD = 3'd4;

  typedef logic [2:0][RowW-1:0] rows_t;

  typedef struct packed {
    logic signed [PtW-1:0] first_x;
    logic signed [PtW-1:0] first_y;
    logic signed [PtW-1:0] second_x;
    logic signed [PtW-1:0] second_y;
    logic                  last_pair;
  } in_word_t;

  typedef struct packed {
    logic [IdxW-1:0]  pair_index;
    logic             is_inlier;
    logic [DistW-1:0] distance;
    logic             set_done;
    logic [CntW-1:0]  inlier_count;
    logic [DistW-1:0] mean_distance;
  } out_word_t;

  // Multiplier operand sources
  typedef enum logic [4:0] {
    OP_ZERO, OP_THR, OP_X1, OP_Y1, OP_X2, OP_Y2, OP_SIXTEEN,
    OP_F00, OP_F01, OP_F02, OP_F10, OP_F11, OP_F12, OP_F20, OP_F21, OP_F22,
    OP_A0, OP_A1, OP_A2, OP_B0, OP_B1, OP_RES, OP_S, OP_T2
  } opsel_e;

  // Where the finished accumulator goes
  typedef enum logic [3:0] {
    WR_NONE, WR_T2, WR_A0, WR_A1, WR_A2, WR_B0, WR_B1, WR_RES, WR_S, WR_NUM, WR_ST
  } wr_e;

  typedef struct packed {
    opsel_e     a_sel;
    logic [1:0] a_chunk;
    opsel_e     b_sel;
    logic [1:0] b_chunk;
    logic       clr;
    wr_e        wr;
  } mac_step_t;

  typedef struct packed {
    logic [87:0]  s;
    logic [124:0] num;
    logic [119:0] st;
  } mac_res_t;

  typedef enum logic {DS_DIV, DS_SQRT} ds_mode_e;

  typedef struct packed {
    logic        load;
    logic        step;
    ds_mode_e    mode;
    logic [135:0] rem_init;
    logic [135:0] dv_init;
  } ds_cmd_t;

  function automatic logic signed [CoefW-1:0] coef_at(logic [RowW-1:0] row, int c);
    return row[CoefW*c +: CoefW];
  endfunction

  function automatic mac_step_t ms(opsel_e a, logic [1:0] ca, opsel_e b, logic [1:0] cb,
                                   logic clr, wr_e wr);
    mac_step_t r;
    r.a_sel = a; r.a_chunk = ca; r.b_sel = b; r.b_chunk = cb; r.clr = clr; r.wr = wr;
    return r;
  endfunction

  // One multiply-accumulate per step; a clearing step stores the previous group
  function automatic mac_step_t mac_prog(logic [StepW-1:0] idx);
    mac_step_t r;
    case (idx)
      // threshold squared
      6'd0:  r = ms(OP_THR, 2'd0, OP_THR, 2'd0, 1'b1, WR_NONE);
      // F * x1
      6'd1:  r = ms(OP_F00, 2'd0, OP_X1, 2'd0, 1'b1, WR_T2);
      6'd2:  r = ms(OP_F01, 2'd0, OP_Y1, 2'd0, 1'b0, WR_NONE);
      6'd3:  r = ms(OP_F02, 2'd0, OP_SIXTEEN, 2'd0, 1'b0, WR_NONE);
      6'd4:  r = ms(OP_F10, 2'd0, OP_X1, 2'd0, 1'b1, WR_A0);
      6'd5:  r = ms(OP_F11, 2'd0, OP_Y1, 2'd0, 1'b0, WR_NONE);
      6'd6:  r = ms(OP_F12, 2'd0, OP_SIXTEEN, 2'd0, 1'b0, WR_NONE);
      6'd7:  r = ms(OP_F20, 2'd0, OP_X1, 2'd0, 1'b1, WR_A1);
      6'd8:  r = ms(OP_F21, 2'd0, OP_Y1, 2'd0, 1'b0, WR_NONE);
      6'd9:  r = ms(OP_F22, 2'd0, OP_SIXTEEN, 2'd0, 1'b0, WR_NONE);
      // F^T * x2, first two terms
      6'd10: r = ms(OP_F00, 2'd0, OP_X2, 2'd0, 1'b1, WR_A2);
      6'd11: r = ms(OP_F10, 2'd0, OP_Y2, 2'd0, 1'b0, WR_NONE);
      6'd12: r = ms(OP_F20, 2'd0, OP_SIXTEEN, 2'd0, 1'b0, WR_NONE);
      6'd13: r = ms(OP_F01, 2'd0, OP_X2, 2'd0, 1'b1, WR_B0);
      6'd14: r = ms(OP_F11, 2'd0, OP_Y2, 2'd0, 1'b0, WR_NONE);
      6'd15: r = ms(OP_F21, 2'd0, OP_SIXTEEN, 2'd0, 1'b0, WR_NONE);
      // residual x2 . (F x1)
      6'd16: r = ms(OP_A0, 2'd0, OP_X2, 2'd0, 1'b1, WR_B1);
      6'd17: r = ms(OP_A0, 2'd1, OP_X2, 2'd0, 1'b0, WR_NONE);
      6'd18: r = ms(OP_A1, 2'd0, OP_Y2, 2'd0, 1'b0, WR_NONE);
      6'd19: r = ms(OP_A1, 2'd1, OP_Y2, 2'd0, 1'b0, WR_NONE);
      6'd20: r = ms(OP_A2, 2'd0, OP_SIXTEEN, 2'd0, 1'b0, WR_NONE);
      6'd21: r = ms(OP_A2, 2'd1, OP_SIXTEEN, 2'd0, 1'b0, WR_NONE);
      // sum of four squares
      6'd22: r = ms(OP_A0, 2'd0, OP_A0, 2'd0, 1'b1, WR_RES);
      6'd23: r = ms(OP_A0, 2'd0, OP_A0, 2'd1, 1'b0, WR_NONE);
      6'd24: r = ms(OP_A0, 2'd1, OP_A0, 2'd0, 1'b0, WR_NONE);
      6'd25: r = ms(OP_A0, 2'd1, OP_A0, 2'd1, 1'b0, WR_NONE);
      6'd26: r = ms(OP_A1, 2'd0, OP_A1, 2'd0, 1'b0, WR_NONE);
      6'd27: r = ms(OP_A1, 2'd0, OP_A1, 2'd1, 1'b0, WR_NONE);
      6'd28: r = ms(OP_A1, 2'd1, OP_A1, 2'd0, 1'b0, WR_NONE);
      6'd29: r = ms(OP_A1, 2'd1, OP_A1, 2'd1, 1'b0, WR_NONE);
      6'd30: r = ms(OP_B0, 2'd0, OP_B0, 2'd0, 1'b0, WR_NONE);
      6'd31: r = ms(OP_B0, 2'd0, OP_B0, 2'd1, 1'b0, WR_NONE);
      6'd32: r = ms(OP_B0, 2'd1, OP_B0, 2'd0, 1'b0, WR_NONE);
      6'd33: r = ms(OP_B0, 2'd1, OP_B0, 2'd1, 1'b0, WR_NONE);
      6'd34: r = ms(OP_B1, 2'd0, OP_B1, 2'd0, 1'b0, WR_NONE);
      6'd35: r = ms(OP_B1, 2'd0, OP_B1, 2'd1, 1'b0, WR_NONE);
      6'd36: r = ms(OP_B1, 2'd1, OP_B1, 2'd0, 1'b0, WR_NONE);
      6'd37: r = ms(OP_B1, 2'd1, OP_B1, 2'd1, 1'b0, WR_NONE);
      // residual squared
      6'd38: r = ms(OP_RES, 2'd0, OP_RES, 2'd0, 1'b1, WR_S);
      6'd39: r = ms(OP_RES, 2'd0, OP_RES, 2'd1, 1'b0, WR_NONE);
      6'd40: r = ms(OP_RES, 2'd1, OP_RES, 2'd0, 1'b0, WR_NONE);
      6'd41: r = ms(OP_RES, 2'd1, OP_RES, 2'd1, 1'b0, WR_NONE);
      // S times threshold squared
      6'd42: r = ms(OP_S, 2'd0, OP_T2, 2'd0, 1'b1, WR_NUM);
      6'd43: r = ms(OP_S, 2'd1, OP_T2, 2'd0, 1'b0, WR_NONE);
      6'd44: r = ms(OP_S, 2'd2, OP_T2, 2'd0, 1'b0, WR_NONE);
      // flush: store the last group
      6'd45: r = ms(OP_ZERO, 2'd0, OP_ZERO, 2'd0, 1'b1, WR_ST);
      default: r = ms(OP_ZERO, 2'd0, OP_ZERO, 2'd0, 1'b0, WR_NONE);
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/sis_mac.sv =====
// Shared 32x32 multiplier with signed wide accumulator and product registers.
module sis_mac (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          issue_i,
  input  logic [sis_pkg::StepW-1:0]     step_i,
  input  sis_pkg::in_word_t             pt_i,
  input  sis_pkg::rows_t                rows_i,
  input  logic [sis_pkg::ThrW-1:0]      thr_i,
  output sis_pkg::mac_res_t             res_o
);
  import sis_pkg::*;

  typedef struct packed {
    logic       vld;
    logic       clr;
    logic       neg;
    logic [1:0] pos;
    wr_e        wr;
  } mac_ctl_t;

  mac_step_t          stp;
  mac_ctl_t           ctl_q;
  logic [63:0]        prod_q;
  logic signed [127:0] acc_q, acc_d;
  logic signed [127:0] a_val, b_val;
  logic [127:0]       a_mag, b_mag, term, base;
  logic [31:0]        a_chk, b_chk;

  logic [31:0]        t2_q;
  logic signed [43:0] a0_q, a1_q, a2_q, b0_q, b1_q;
  logic signed [63:0] rs_q;
  logic [87:0]        s_q;
  logic [124:0]       num_q;
  logic [119:0]       st_q;

  function automatic logic signed [127:0] opnd(opsel_e sel);
    logic signed [127:0] v;
    case (sel)
      OP_THR:     v = 128'(signed'({1'b0, thr_i}));
      OP_X1:      v = 128'(pt_i.first_x);
      OP_Y1:      v = 128'(pt_i.first_y);
      OP_X2:      v = 128'(pt_i.second_x);
      OP_Y2:      v = 128'(pt_i.second_y);
      OP_SIXTEEN: v = 128'sd16;
      OP_F00:     v = 128'(coef_at(rows_i[0], 0));
      OP_F01:     v = 128'(coef_at(rows_i[0], 1));
      OP_F02:     v = 128'(coef_at(rows_i[0], 2));
      OP_F10:     v = 128'(coef_at(rows_i[1], 0));
      OP_F11:     v = 128'(coef_at(rows_i[1], 1));
      OP_F12:     v = 128'(coef_at(rows_i[1], 2));
      OP_F20:     v = 128'(coef_at(rows_i[2], 0));
      OP_F21:     v = 128'(coef_at(rows_i[2], 1));
      OP_F22:     v = 128'(coef_at(rows_i[2], 2));
      OP_A0:      v = 128'(a0_q);
      OP_A1:      v = 128'(a1_q);
      OP_A2:      v = 128'(a2_q);
      OP_B0:      v = 128'(b0_q);
      OP_B1:      v = 128'(b1_q);
      OP_RES:     v = 128'(rs_q);
      OP_S:       v = 128'(signed'({1'b0, s_q}));
      OP_T2:      v = 128'(signed'({1'b0, t2_q}));
      default:    v = '0;
    endcase
    return v;
  endfunction

  // Operand select, sign split and chunk pick
  always_comb begin
    stp   = mac_prog(step_i);
    a_val = opnd(stp.a_sel);
    b_val = opnd(stp.b_sel);
    a_mag = a_val[127] ? 128'(-a_val) : 128'(a_val);
    b_mag = b_val[127] ? 128'(-b_val) : 128'(b_val);
    a_chk = a_mag[32*stp.a_chunk +: 32];
    b_chk = b_mag[32*stp.b_chunk +: 32];
  end

  // Accumulate the registered product at its chunk offset
  always_comb begin
    term  = 128'(prod_q) << {ctl_q.pos, 5'd0};
    base  = ctl_q.clr ? '0 : 128'(acc_q);
    acc_d = ctl_q.neg ? signed'(base - term) : signed'(base + term);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q.vld <= issue_i;
      ctl_q.clr <= stp.clr;
      ctl_q.neg <= a_val[127] ^ b_val[127];
      ctl_q.pos <= stp.a_chunk + stp.b_chunk;
      ctl_q.wr  <= stp.wr;
    end
  end

  // Product, accumulator and stored group results
  always_ff @(posedge clk_i) begin
    prod_q <= a_chk * b_chk;
    if (ctl_q.vld) begin
      acc_q <= acc_d;
      case (ctl_q.wr)
        WR_T2:   t2_q  <= acc_q[31:0];
        WR_A0:   a0_q  <= acc_q[43:0];
        WR_A1:   a1_q  <= acc_q[43:0];
        WR_A2:   a2_q  <= acc_q[43:0];
        WR_B0:   b0_q  <= acc_q[43:0];
        WR_B1:   b1_q  <= acc_q[43:0];
        WR_RES:  rs_q  <= acc_q[63:0];
        WR_S:    s_q   <= acc_q[87:0];
        WR_NUM:  num_q <= acc_q[124:0];
        WR_ST:   st_q  <= acc_q[119:0];
        default: ;
      endcase
    end
  end

  assign res_o.s   = s_q;
  assign res_o.num = num_q;
  assign res_o.st  = st_q;

endmodule

// ===== rtl/sis_dsu.sv =====
// Shared subtract unit: restoring division and integer square root, one bit a cycle on step.
module sis_dsu (
  input  logic             clk_i,
  input  sis_pkg::ds_cmd_t cmd_i,
  output logic [47:0]      q_o
);
  import sis_pkg::*;

  logic [135:0] rem_q, dv_q, opy;
  logic [47:0]  q_q, rt;
  logic [136:0] diff;
  logic         ge;

  // One subtract serves both modes
  always_comb begin
    rt   = q_q + dv_q[47:0];
    opy  = (cmd_i.mode == DS_SQRT) ? 136'(rt) : dv_q;
    diff = {1'b0, rem_q} - {1'b0, opy};
    ge   = !diff[136];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q <= cmd_i.rem_init;
      dv_q  <= cmd_i.dv_init;
      q_q   <= '0;
    end else if (cmd_i.step) begin
      if (ge) rem_q <= diff[135:0];
      if (cmd_i.mode == DS_SQRT) begin
        q_q  <= ge ? ((q_q >> 1) + dv_q[47:0]) : (q_q >> 1);
        dv_q <= dv_q >> 2;
      end else begin
        q_q  <= {q_q[46:0], ge};
        dv_q <= dv_q >> 1;
      end
    end
  end

  assign q_o = q_q;

endmodule

// ===== rtl/sampson_inlier_scorer.sv =====
// Top level: config registers, sequencer, set totals and output word register.
//
//  channel | direction | handshake                    | word
//  in      | input     | in_valid_i / in_stall_o      | in_word_i  (in_word_t)
//  out     | output    | out_valid_o / out_stall_i    | out_word_o (out_word_t)
//  cfg     | input     | cfg_we_i, cfg_idx_i          | cfg_wdata_i
//
// A pair runs on the shared multiplier, then the divider and the square root, plus control,
// before the next word is accepted; no new pair is taken while one is in flight. A saturated
// distance skips divide and root; a last pair with inliers adds the mean division.
// Reset clears the registers to their defaults and the totals to zero.
// The next word is taken while a finished word waits; the block holds before loading
// the output register only if the previous word is still stalled.
module sampson_inlier_scorer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  sis_pkg::in_word_t              in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output sis_pkg::out_word_t             out_word_o,
  input  logic                           cfg_we_i,
  input  logic [sis_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [sis_pkg::CfgW-1:0]       cfg_wdata_i
);
  import sis_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_MAC  = 8'b00000010,
    S_CHK  = 8'b00000100,
    S_DIV  = 8'b00001000,
    S_SQRT = 8'b00010000,
    S_UPD  = 8'b00100000,
    S_MEAN = 8'b01000000,
    S_FIN  = 8'b10000000
  } state_e;

  state_e            state_q, state_d;
  logic [5:0]        cnt_q, cnt_d;
  rows_t             rows_q;
  logic [FracW-1:0]  cfb_q;
  logic [ThrW-1:0]   thr_q;
  in_word_t          in_q;
  logic [IdxW-1:0]   idx_q;
  logic [CntW-1:0]   tot_q;
  logic [SumW-1:0]   sum_q;
  logic              inl_q, sat_q, msel_q;
  logic [DistW-1:0]  dist_q;
  out_word_t         out_q, out_w;
  logic              out_vld_q;

  mac_res_t          mres;
  ds_cmd_t           cmd;
  logic [47:0]       q;
  logic              in_acc, issue, load_out;
  logic [FracW-1:0]  fb;
  logic [6:0]        fb2;
  logic [87:0]       lim;
  logic              tiny, sat, inl;
  logic [DistW-1:0]  dist_w;
  logic [CntW-1:0]   tot_w;
  logic [SumW:0]     sum_x;
  logic [SumW-1:0]   sum_w;
  logic              mean_go;
  logic [IdxW:0]     idx_inc;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign issue      = (state_q == S_MAC) && (cnt_q < 6'(NumSteps));
  assign load_out   = (state_q == S_FIN) && (!out_vld_q || !out_stall_i);

  sis_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .issue_i(issue),
    .step_i (cnt_q),
    .pt_i   (in_q),
    .rows_i (rows_q),
    .thr_i  (thr_q),
    .res_o  (mres)
  );

  sis_dsu u_dsu (
    .clk_i(clk_i),
    .cmd_i(cmd),
    .q_o  (q)
  );

  // Denominator, inlier and saturation tests
  always_comb begin
    fb   = (cfb_q > FracW'(MaxFrac)) ? FracW'(MaxFrac) : cfb_q;
    fb2  = {fb, 1'b0};
    lim  = (fb2 >= 7'(TinyOffset)) ? (88'(1) << (fb2 - 7'(TinyOffset))) : '0;
    tiny = (mres.s <= lim);
    inl  = !tiny && ({mres.num, 8'd0} <= 133'(mres.st));
    sat  = tiny || (128'(mres.num) >= {mres.s, 40'd0});
  end

  // Distance and running totals
  always_comb begin
    dist_w  = sat_q ? Ones24 : q[DistW-1:0];
    tot_w   = tot_q;
    sum_w   = sum_q;
    sum_x   = {1'b0, sum_q} + (SumW+1)'(dist_w);
    if (inl_q) begin
      if (32'(tot_q) < CountCap) tot_w = tot_q + 17'd1;
      sum_w = sum_x[SumW] ? Ones40 : sum_x[SumW-1:0];
    end
    mean_go = in_q.last_pair && (tot_w != '0);
    idx_inc = {1'b0, idx_q} + 17'd1;
  end

  // Commands to the divide and root unit
  always_comb begin
    cmd = '0;
    cmd.mode = DS_DIV;
    case (state_q)
      S_CHK: begin
        if (!sat) begin
          cmd.load     = 1'b1;
          cmd.rem_init = 136'({mres.num, 8'd0});
          cmd.dv_init  = 136'(mres.s) << (DivIters - 1);
        end
      end
      S_DIV: cmd.step = 1'b1;
      S_SQRT: begin
        cmd.mode = DS_SQRT;
        if (cnt_q == '0) begin
          cmd.load     = 1'b1;
          cmd.rem_init = 136'(q);
          cmd.dv_init  = 136'(1) << (2*SqrtIters - 2);
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_UPD: begin
        if (mean_go) begin
          cmd.load     = 1'b1;
          cmd.rem_init = 136'(sum_w);
          cmd.dv_init  = 136'(tot_w) << (MeanIters - 1);
        end
      end
      S_MEAN: cmd.step = 1'b1;
      default: ;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + 6'd1;
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (in_acc) state_d = S_MAC;
      end
      S_MAC: begin
        if (cnt_q == 6'(NumSteps)) begin
          state_d = S_CHK;
          cnt_d   = '0;
        end
      end
      S_CHK: begin
        cnt_d   = '0;
        state_d = sat ? S_UPD : S_DIV;
      end
      S_DIV: begin
        if (cnt_q == 6'(DivIters - 1)) begin
          state_d = S_SQRT;
          cnt_d   = '0;
        end
      end
      S_SQRT: begin
        if (cnt_q == 6'(SqrtIters)) begin
          state_d = S_UPD;
          cnt_d   = '0;
        end
      end
      S_UPD: begin
        cnt_d   = '0;
        state_d = mean_go ? S_MEAN : S_FIN;
      end
      S_MEAN: begin
        if (cnt_q == 6'(MeanIters - 1)) begin
          state_d = S_FIN;
          cnt_d   = '0;
        end
      end
      S_FIN: begin
        cnt_d = '0;
        if (load_out) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  // Result word
  always_comb begin
    out_w.pair_index    = idx_q;
    out_w.is_inlier     = inl_q;
    out_w.distance      = dist_q;
    out_w.set_done      = in_q.last_pair;
    out_w.inlier_count  = tot_q;
    out_w.mean_distance = msel_q ? q[DistW-1:0] : (in_q.last_pair ? Ones24 : '0);
  end

  // Control state, config and totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      rows_q    <= '0;
      cfb_q     <= FracW'(20);
      thr_q     <= ThrW'(768);
      idx_q     <= '0;
      tot_q     <= '0;
      sum_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROW_ZERO:  rows_q[0] <= cfg_wdata_i[RowW-1:0];
          CFG_ROW_ONE:   rows_q[1] <= cfg_wdata_i[RowW-1:0];
          CFG_ROW_TWO:   rows_q[2] <= cfg_wdata_i[RowW-1:0];
          CFG_FRAC_BITS: cfb_q     <= cfg_wdata_i[FracW-1:0];
          CFG_THRESHOLD: thr_q     <= cfg_wdata_i[ThrW-1:0];
          default: ;
        endcase
      end
      if (state_q == S_UPD) begin
        tot_q <= tot_w;
        sum_q <= sum_w;
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
        if (in_q.last_pair) begin
          idx_q <= '0;
          tot_q <= '0;
          sum_q <= '0;
        end else begin
          idx_q <= (32'(idx_inc) == MaxPoints) ? '0 : idx_inc[IdxW-1:0];
        end
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Item payload and per-pair flags
  always_ff @(posedge clk_i) begin
    if (in_acc) in_q <= in_word_i;
    if (state_q == S_CHK) begin
      inl_q <= inl;
      sat_q <= sat;
    end
    if (state_q == S_UPD) begin
      dist_q <= dist_w;
      msel_q <= mean_go;
    end
    if (load_out) out_q <= out_w;
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

`ifndef ASSERT_OFF
  // an accepted word starts the multiply program
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_MAC && cnt_q == '0))
    else $error("accepted word did not start the multiply program");

  // inlier count stays at or under its cap
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(tot_q) <= CountCap)
    else $error("inlier count above cap");

  // an inlier distance is below the threshold range
  a_inl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.is_inlier) |-> (out_word_o.distance[23:16] == '0))
    else $error("inlier with out-of-range distance");

  // mean is zero except on the last pair
  a_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.set_done) |-> (out_word_o.mean_distance == '0))
    else $error("mean reported before the end of a set");
`endif

endmodule
